/* design/counter_lfsr_hash_rng_core_defines.svh */
// Assertion macros shared by the random number generator RTL.
`ifndef COUNTER_LFSR_HASH_RNG_CORE_DEFINES_SVH
`define COUNTER_LFSR_HASH_RNG_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define CRNG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define CRNG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/crng_pkg.sv */
// Types and constants of the counter/LFSR/hash random number generator.
`timescale 1ns / 1ps
`default_nettype none

package crng_pkg;

  localparam logic [1:0] CMD_RAW   = 2'd0;
  localparam logic [1:0] CMD_BELOW = 2'd1;
  localparam logic [1:0] CMD_RANGE = 2'd2;
  localparam logic [1:0] CMD_SEED  = 2'd3;

  localparam logic [31:0] HASH_ADD    = 32'd394442897;
  localparam logic [31:0] HASH_MUL_A  = 32'd2426389093;
  localparam logic [31:0] HASH_MUL_B  = 32'd2840406347;
  localparam logic [31:0] RESET_COUNT = 32'h20078332;
  localparam logic [31:0] RESET_JUMP  = 32'hcafebabe;
  localparam logic [31:0] RESET_KEY   = 32'hbaddecaf;
  localparam logic [31:0] LFSR_TAPS   = 32'd80000967;
  localparam logic [31:0] WORD_MAX    = 32'hffffffff;

  localparam int unsigned HASH_STAGES = 5;
  localparam int unsigned DIV_STEPS   = 32;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  // Work classes handed from the front end to the execution engine.
  typedef enum logic [1:0] {
    OP_RAW,
    OP_BOUND,
    OP_ZERO,
    OP_SEED
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] bound;
    logic [31:0] offset;
    logic [63:0] seed;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [31:0] value;
    logic [31:0] key;
  } hash_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] value;
  } hash_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

/* design/crng_front.sv */
// Front end: accepts commands, classifies them and queues the work entries.
`timescale 1ns / 1ps
`default_nettype none

module crng_front #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        command_i,
  input  wire logic [31:0]       limit_i,
  input  wire logic [31:0]       lower_i,
  input  wire logic [31:0]       upper_i,
  input  wire logic [63:0]       seed_value_i,
  output logic                   head_valid_o,
  output crng_pkg::entry_t       head_o,
  input  wire logic              pop_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  crng_pkg::entry_t queue_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntW-1:0]  count_q;

  crng_pkg::entry_t entry;
  logic [31:0]      size;
  logic [63:0]      xs_a;
  logic [63:0]      xs_b;
  logic [63:0]      xs_c;
  logic             push;
  logic             pop;

  assign size = upper_i - lower_i + 32'd1;
  assign xs_a = seed_value_i ^ (seed_value_i << 13);
  assign xs_b = xs_a ^ (xs_a >> 7);
  assign xs_c = xs_b ^ (xs_b << 17);

  always_comb begin
    entry        = '0;
    entry.op     = crng_pkg::OP_RAW;
    entry.bound  = limit_i;
    entry.offset = 32'd0;
    entry.seed   = xs_c;
    unique case (command_i)
      crng_pkg::CMD_RAW: begin
        entry.op = crng_pkg::OP_RAW;
      end
      crng_pkg::CMD_BELOW: begin
        entry.op = (limit_i == 32'd0) ? crng_pkg::OP_ZERO : crng_pkg::OP_BOUND;
      end
      crng_pkg::CMD_RANGE: begin
        entry.op     = (size == 32'd0) ? crng_pkg::OP_ZERO : crng_pkg::OP_BOUND;
        entry.bound  = size;
        entry.offset = lower_i;
      end
      crng_pkg::CMD_SEED: begin
        entry.op = crng_pkg::OP_SEED;
      end
      default: begin
        entry.op = crng_pkg::OP_RAW;
      end
    endcase
  end

  assign in_ready_o   = (count_q != FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_o       = queue_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* design/crng_hash.sv */
// Pipelined multiply/xorshift hash unit; done flags the result of each start.
`timescale 1ns / 1ps
`default_nettype none

module crng_hash (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire crng_pkg::hash_req_t req_i,
  output crng_pkg::hash_rsp_t      rsp_o
);

  logic [crng_pkg::HASH_STAGES-1:0] vld_q;
  logic [31:0] s1_q;
  logic [31:0] key_q;
  logic [31:0] s2_q;
  logic [31:0] s3_q;
  logic [31:0] s4_q;
  logic [31:0] s5_q;

  logic [31:0] sum_key;
  logic [31:0] sum_add;

  assign sum_key = s1_q + key_q;
  assign sum_add = s2_q + crng_pkg::HASH_ADD;

  always_ff @(posedge clk_i) begin
    s1_q  <= req_i.value * crng_pkg::HASH_MUL_A;
    key_q <= req_i.key;
    s2_q  <= sum_key ^ (sum_key << 13);
    s3_q  <= sum_add ^ (sum_add >> 17);
    s4_q  <= s3_q * crng_pkg::HASH_MUL_B;
    s5_q  <= s4_q ^ (s4_q << 5);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[crng_pkg::HASH_STAGES-2:0], req_i.start};
    end
  end

  assign rsp_o.busy  = |vld_q;
  assign rsp_o.done  = vld_q[crng_pkg::HASH_STAGES-1];
  assign rsp_o.value = s5_q;

endmodule

`default_nettype wire

/* design/crng_div.sv */
// Restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module crng_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire crng_pkg::div_req_t req_i,
  output crng_pkg::div_rsp_t      rsp_o
);

  logic [31:0] rem_q;
  logic [31:0] dvd_q;
  logic [31:0] dsr_q;
  logic [crng_pkg::DIV_CNT_W-1:0] cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  assign trial = {rem_q, dvd_q[31]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= 32'd0;
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? diff[31:0] : trial[31:0];
      dvd_q <= {dvd_q[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q  <= crng_pkg::DIV_CNT_W'(crng_pkg::DIV_STEPS);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - crng_pkg::DIV_CNT_W'(1);
        if (cnt_q == crng_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

/* design/crng_back.sv */
// Execution engine: generator state, draw sequencing and result register.
`timescale 1ns / 1ps
`default_nettype none

module crng_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                head_valid_i,
  input  wire crng_pkg::entry_t    head_i,
  output logic                     pop_o,
  output crng_pkg::hash_req_t      hash_req_o,
  input  wire crng_pkg::hash_rsp_t hash_rsp_i,
  output crng_pkg::div_req_t       div_req_o,
  input  wire crng_pkg::div_rsp_t  div_rsp_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [31:0]              value_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TDIV,
    ST_DRAW,
    ST_HASH,
    ST_RDIV,
    ST_OUT,
    ST_SEED
  } state_e;

  state_e        state_q;
  crng_pkg::op_e op_q;
  logic [31:0]   counter_q;
  logic [31:0]   jumper_q;
  logic [31:0]   key_q;
  logic [31:0]   bound_q;
  logic [31:0]   offset_q;
  logic [31:0]   thresh_q;
  logic [31:0]   result_q;
  logic          hash_start_q;
  logic [31:0]   hash_val_q;
  logic [31:0]   hash_key_q;
  logic          div_start_q;
  logic [31:0]   div_dvd_q;
  logic [31:0]   div_dsr_q;
  logic          out_valid_q;
  logic [31:0]   value_q;

  logic [31:0]   counter_next;
  logic [31:0]   jumper_next;
  logic          hash_start_d;
  logic          div_start_d;
  logic          out_valid_d;

  assign counter_next = counter_q + 32'd1;
  assign jumper_next  = (jumper_q >> 1) ^ (jumper_q[0] ? crng_pkg::LFSR_TAPS : 32'd0);

  assign pop_o = (state_q == ST_IDLE) && head_valid_i;

  assign hash_start_d = (pop_o && (head_i.op == crng_pkg::OP_SEED)) || (state_q == ST_DRAW);
  assign div_start_d  = (pop_o && (head_i.op == crng_pkg::OP_BOUND)) ||
                        ((state_q == ST_HASH) && hash_rsp_i.done &&
                         (op_q != crng_pkg::OP_RAW) && (hash_rsp_i.value < thresh_q));
  // A pending result stays valid until taken; ST_OUT always leaves a valid result.
  assign out_valid_d  = (state_q == ST_OUT) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= crng_pkg::OP_RAW;
      counter_q    <= crng_pkg::RESET_COUNT;
      jumper_q     <= crng_pkg::RESET_JUMP;
      key_q        <= crng_pkg::RESET_KEY;
      bound_q      <= 32'd0;
      offset_q     <= 32'd0;
      thresh_q     <= 32'd0;
      result_q     <= 32'd0;
      hash_start_q <= 1'b0;
      hash_val_q   <= 32'd0;
      hash_key_q   <= 32'd0;
      div_start_q  <= 1'b0;
      div_dvd_q    <= 32'd0;
      div_dsr_q    <= 32'd0;
      out_valid_q  <= 1'b0;
      value_q      <= 32'd0;
    end else begin
      hash_start_q <= hash_start_d;
      div_start_q  <= div_start_d;
      out_valid_q  <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (head_valid_i) begin
            op_q     <= head_i.op;
            bound_q  <= head_i.bound;
            offset_q <= head_i.offset;
            unique case (head_i.op)
              crng_pkg::OP_RAW: begin
                state_q <= ST_DRAW;
              end
              crng_pkg::OP_BOUND: begin
                // Rejection threshold needs the remainder of the all-ones word first.
                div_dvd_q   <= crng_pkg::WORD_MAX;
                div_dsr_q   <= head_i.bound;
                state_q     <= ST_TDIV;
              end
              crng_pkg::OP_ZERO: begin
                result_q <= 32'd0;
                state_q  <= ST_OUT;
              end
              crng_pkg::OP_SEED: begin
                hash_val_q   <= head_i.seed[31:0];
                hash_key_q   <= head_i.seed[63:32];
                counter_q    <= head_i.seed[31:0];
                jumper_q     <= crng_pkg::RESET_JUMP;
                state_q      <= ST_SEED;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_TDIV: begin
          if (div_rsp_i.done) begin
            thresh_q <= crng_pkg::WORD_MAX - div_rsp_i.rem;
            state_q  <= ST_DRAW;
          end
        end
        ST_DRAW: begin
          counter_q    <= counter_next;
          jumper_q     <= jumper_next;
          hash_val_q   <= jumper_next ^ counter_next;
          hash_key_q   <= key_q;
          state_q      <= ST_HASH;
        end
        ST_HASH: begin
          if (hash_rsp_i.done) begin
            if (op_q == crng_pkg::OP_RAW) begin
              result_q <= hash_rsp_i.value;
              state_q  <= ST_OUT;
            end else if (hash_rsp_i.value >= thresh_q) begin
              // Rejected words still advance the generator state.
              state_q <= ST_DRAW;
            end else begin
              div_dvd_q   <= hash_rsp_i.value;
              div_dsr_q   <= bound_q;
              state_q     <= ST_RDIV;
            end
          end
        end
        ST_RDIV: begin
          if (div_rsp_i.done) begin
            result_q <= div_rsp_i.rem + offset_q;
            state_q  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            value_q     <= result_q;
            state_q     <= ST_IDLE;
          end
        end
        ST_SEED: begin
          if (hash_rsp_i.done) begin
            key_q   <= hash_rsp_i.value;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign hash_req_o.start   = hash_start_q;
  assign hash_req_o.value   = hash_val_q;
  assign hash_req_o.key     = hash_key_q;
  assign div_req_o.start    = div_start_q;
  assign div_req_o.dividend = div_dvd_q;
  assign div_req_o.divisor  = div_dsr_q;
  assign out_valid_o        = out_valid_q;
  assign value_o            = value_q;

endmodule

`default_nettype wire

/* design/counter_lfsr_hash_rng_core.sv */
// Top level of the counter/LFSR/hash random number generator.
//
// Commands arrive on a valid/ready input channel (command, limit, lower,
// upper, seed_value); results leave on a valid/ready output channel (value).
// Command 0 returns a raw hashed word, 1 a value below limit, 2 a value in
// [lower, upper], and 3 reseeds the generator without returning a result.
// A small command queue sits in front of the engine, so new transactions are
// taken while the engine works or while a result waits to be taken.
// Raw draw: the word passes through the five-stage hash pipeline, and the
// engine takes the next command only once the last result is registered.
// Bounded draws: the remainder of the all-ones word gives the rejection
// threshold, words are then drawn and hashed until one falls below it, and
// the remainder of that word gives the result; the remainder unit works one
// bit per cycle. Zero-size bounded commands give 0 without a draw; a reseed
// keeps the engine busy until the hash of the seed is done.
// Reset loads the counter, jumper and key with their default values and
// empties the queue. When the receiver stalls, the result register holds and
// the engine waits; the queue keeps accepting until it is full.
`timescale 1ns / 1ps
`default_nettype none
`include "counter_lfsr_hash_rng_core_defines.svh"

module counter_lfsr_hash_rng_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] limit_i,
  input  wire logic [31:0] lower_i,
  input  wire logic [31:0] upper_i,
  input  wire logic [63:0] seed_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      value_o
);

  logic                head_valid;
  crng_pkg::entry_t    head;
  logic                pop;
  crng_pkg::hash_req_t hash_req;
  crng_pkg::hash_rsp_t hash_rsp;
  crng_pkg::div_req_t  div_req;
  crng_pkg::div_rsp_t  div_rsp;

  crng_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .limit_i      (limit_i),
    .lower_i      (lower_i),
    .upper_i      (upper_i),
    .seed_value_i (seed_value_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  crng_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hash_req),
    .rsp_o  (hash_rsp)
  );

  crng_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  crng_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .hash_req_o   (hash_req),
    .hash_rsp_i   (hash_rsp),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o)
  );

  `CRNG_ASSERT_IMP(a_hash_start_idle, hash_req.start, !hash_rsp.busy,
                   "hash started while a hash is in flight")
  `CRNG_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy,
                   "remainder unit started while busy")
  `CRNG_ASSERT_IMP(a_no_overlap, hash_req.start, !div_rsp.busy && !div_req.start,
                   "hash and remainder unit active together")
  `CRNG_ASSERT_NXT(a_div_runs, div_req.start, div_rsp.busy,
                   "remainder unit did not start")

endmodule

`default_nettype wire
